[src/log_law_yplus_solver_core_defines.svh]
// assertion macros for the log-law y+ solver
// used by the modules that carry concurrent checks; no other dependencies
`ifndef LOG_LAW_YPLUS_SOLVER_CORE_DEFINES_SVH
`define LOG_LAW_YPLUS_SOLVER_CORE_DEFINES_SVH
`ifndef SYNTH
`define LLYS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define LLYS_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LLYS_ASSERT(lbl, clk, rstn, prop, msg)
`define LLYS_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

[src/llys_pkg.sv]
// shared types, constants and the ln table function for the y+ solver
// no dependencies
package llys_pkg;

  localparam int unsigned MAX_UPDATES_DEF = 10;
  localparam int unsigned LOG_TABLE_DEPTH_DEF = 256;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned KAPPA_W = 18;
  localparam int unsigned E_W = 24;
  localparam int unsigned CFG_W = 24;
  localparam int unsigned KRE_W = 48;
  localparam int unsigned Y_W = 32;
  localparam int unsigned LNT_W = 17;

  localparam logic [KAPPA_W-1:0] KAPPA_RESET = 18'd26870;
  localparam logic [E_W-1:0] E_RESET = 24'd642253;
  localparam logic [Y_W-1:0] YPLUS_START = 32'd737280;
  localparam logic signed [31:0] LN2_Q16 = 32'sd45426;
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  localparam logic [1:0] CFG_KAPPA = 2'd0;
  localparam logic [1:0] CFG_E = 2'd1;

  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_MAXED = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_DEGEN = 2'd3;

  typedef struct packed {
    logic invalid;
    logic [KRE_W-1:0] kre;
  } qentry_t;

  // ln(1 + i/depth) in q16.16 via the atanh series
  function automatic logic [31:0] ln_entry(input int unsigned i, input int unsigned depth);
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] term;
    logic [63:0] sum;
    z = (64'(i) << 32) / 64'(2 * depth + i);
    z2 = (z * z) >> 32;
    term = z;
    sum = '0;
    for (int k = 0; k < 24; k++) begin
      sum = sum + term / 64'(2 * k + 1);
      term = (term * z2) >> 32;
    end
    return 32'((2 * sum + 64'd32768) >> 16);
  endfunction

endpackage

[src/log_law_yplus_solver_core.sv]
// top level of the log-law y+ solver: config registers, front end, queue, back end
// depends on llys_pkg, llys_front, llys_fifo, llys_back
//
// channel   ports                                   handshake
// input     start, busy, in_*                       beat taken when start & !busy
// result    out_valid, out_*                        one-cycle strobe, no back-pressure
// config    cfg_we, cfg_index, cfg_data             write when cfg_we high
//
// front end: limb products, then a bit-serial divide for each face
// each update: multiply, normalise, ln index and table, denominator, divide, update
// up to MAX_UPDATES updates per face
// rst_n clears control state; the ln table is constant logic, no fill pass
// the queue lets the front take the next face while the back end iterates
module log_law_yplus_solver_core
  import llys_pkg::*;
#(
  parameter int unsigned MAX_UPDATES = MAX_UPDATES_DEF,
  parameter int unsigned LOG_TABLE_DEPTH = LOG_TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [31:0]       in_wall_speed,
  input  logic [31:0]       in_wall_distance,
  input  logic [31:0]       in_fluid_density,
  input  logic [47:0]       in_dynamic_viscosity,
  output logic              out_valid,
  output logic [31:0]       out_yplus_value,
  output logic [3:0]        out_update_count,
  output logic [1:0]        out_solve_status,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  logic [KAPPA_W-1:0] kappa_r;
  logic [E_W-1:0]     e_r;
  logic               q_push, q_pop, q_full, q_empty;
  qentry_t            q_in, q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kappa_r <= KAPPA_RESET;
      e_r <= E_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KAPPA: kappa_r <= cfg_data[KAPPA_W-1:0];
        CFG_E: e_r <= cfg_data[E_W-1:0];
        default: ;
      endcase
    end
  end

  llys_front u_front (
    .clk, .rst_n, .start,
    .in_wall_speed, .in_wall_distance, .in_fluid_density, .in_dynamic_viscosity,
    .kappa(kappa_r), .q_full, .busy, .q_push, .q_data(q_in)
  );

  llys_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk, .rst_n, .push(q_push), .push_data(q_in), .pop(q_pop),
    .pop_data(q_out), .full(q_full), .empty(q_empty)
  );

  llys_back #(.MAX_UPDATES(MAX_UPDATES), .LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)) u_back (
    .clk, .rst_n, .e_val(e_r), .q_empty, .q_data(q_out), .q_pop,
    .out_valid, .out_yplus_value, .out_update_count, .out_solve_status
  );

endmodule

[src/llys_front.sv]
// front end: takes a face, flags invalid input, forms kRe by limb products
// and a bit-serial divide; depends on llys_pkg
module llys_front
  import llys_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [31:0]         in_wall_speed,
  input  logic [31:0]         in_wall_distance,
  input  logic [31:0]         in_fluid_density,
  input  logic [47:0]         in_dynamic_viscosity,
  input  logic [KAPPA_W-1:0]  kappa,
  input  logic                q_full,
  output logic                busy,
  output logic                q_push,
  output qentry_t             q_data
);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_DIV, F_PUSH} fstate_t;

  fstate_t      state_r;
  logic [31:0]  speed_r, dist_r, rho_r;
  logic [47:0]  mu_r;
  logic [127:0] w_r;
  logic [31:0]  carry_r;
  logic [1:0]   fi_r, li_r;
  logic [55:0]  rem_r;
  logic [6:0]   bit_r;
  logic [63:0]  q_r;
  logic         over_r, invalid_r;

  logic [31:0]  mult_m, limb;
  logic [63:0]  prod;
  logic [56:0]  rem_sh, den57;
  logic         ge;

  always_comb begin
    case (fi_r)
      2'd0: mult_m = speed_r;
      2'd1: mult_m = dist_r;
      default: mult_m = rho_r;
    endcase
    limb = w_r[{li_r, 5'b0} +: 32];
    prod = 64'(limb) * 64'(mult_m) + 64'(carry_r);
    rem_sh = {rem_r, w_r[bit_r]};
    den57 = {1'b0, mu_r, 8'b0};
    ge = rem_sh >= den57;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (start) begin
            speed_r <= in_wall_speed;
            dist_r <= in_wall_distance;
            rho_r <= in_fluid_density;
            mu_r <= in_dynamic_viscosity;
            w_r <= 128'(kappa);
            carry_r <= '0;
            fi_r <= '0;
            li_r <= '0;
            q_r <= '0;
            over_r <= 1'b0;
            invalid_r <= (in_fluid_density == '0) || (in_dynamic_viscosity == '0);
            if ((in_fluid_density == '0) || (in_dynamic_viscosity == '0)) begin
              state_r <= F_PUSH;
            end else begin
              state_r <= F_MUL;
            end
          end
        end
        F_MUL: begin
          w_r[{li_r, 5'b0} +: 32] <= prod[31:0];
          if (li_r == 2'd3) begin
            li_r <= '0;
            carry_r <= '0;
            if (fi_r == 2'd2) begin
              rem_r <= '0;
              bit_r <= 7'd127;
              state_r <= F_DIV;
            end else begin
              fi_r <= fi_r + 2'd1;
            end
          end else begin
            li_r <= li_r + 2'd1;
            carry_r <= prod[63:32];
          end
        end
        F_DIV: begin
          rem_r <= ge ? 56'(rem_sh - den57) : rem_sh[55:0];
          if (ge && bit_r[6]) over_r <= 1'b1;
          if (!bit_r[6]) q_r <= {q_r[62:0], ge};
          if (bit_r == '0) state_r <= F_PUSH;
          else bit_r <= bit_r - 7'd1;
        end
        F_PUSH: begin
          if (!q_full) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign busy = state_r != F_IDLE;
  assign q_push = (state_r == F_PUSH) && !q_full;
  assign q_data.invalid = invalid_r;
  assign q_data.kre = (over_r || (q_r[63:KRE_W] != '0)) ? '1 : q_r[KRE_W-1:0];

endmodule

[src/llys_fifo.sv]
// short queue of classified faces between front and back end
// depends on llys_pkg
module llys_fifo
  import llys_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  qentry_t push_data,
  input  logic    pop,
  output qentry_t pop_data,
  output logic    full,
  output logic    empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  qentry_t        mem [DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;

  assign full = cnt_r == (AW+1)'(DEPTH);
  assign empty = cnt_r == '0;
  assign pop_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (pop) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

[src/llys_back.sv]
// back end: log-law iteration with a multiplier, normaliser, ln table
// and bit-serial divider; depends on llys_pkg and the assertion macros
`include "log_law_yplus_solver_core_defines.svh"
module llys_back
  import llys_pkg::*;
#(
  parameter int unsigned MAX_UPDATES = MAX_UPDATES_DEF,
  parameter int unsigned LOG_TABLE_DEPTH = LOG_TABLE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [E_W-1:0]  e_val,
  input  logic            q_empty,
  input  qentry_t         q_data,
  output logic            q_pop,
  output logic            out_valid,
  output logic [31:0]     out_yplus_value,
  output logic [3:0]      out_update_count,
  output logic [1:0]      out_solve_status
);

  localparam int unsigned CW = $clog2(MAX_UPDATES + 1);
  localparam int unsigned IW = $clog2(LOG_TABLE_DEPTH);

  typedef enum logic [3:0] {
    B_IDLE, B_MUL, B_NORM, B_IDX, B_ROM, B_DEN, B_DIV, B_UPD
  } bstate_t;

  logic [LNT_W-1:0] ln_rom [LOG_TABLE_DEPTH];

  for (genvar g = 0; g < LOG_TABLE_DEPTH; g++) begin : g_rom
    assign ln_rom[g] = LNT_W'(ln_entry(g, LOG_TABLE_DEPTH));
  end

  bstate_t          state_r;
  logic [KRE_W-1:0] kre_r;
  logic [Y_W-1:0]   y_r;
  logic [CW-1:0]    cnt_r;
  logic [55:0]      v_r;
  logic [5:0]       p_r;
  logic [IW-1:0]    idx_r;
  logic [LNT_W-1:0] t_r;
  logic [20:0]      den_r, rem_r;
  logic [64:0]      dvd_r;
  logic [6:0]       bit_r;
  logic [31:0]      q_r;
  logic             over_r;
  logic             out_valid_r;
  logic [31:0]      out_y_r;
  logic [3:0]       out_cnt_r;
  logic [1:0]       out_st_r;

  logic [63:0]        idx_prod;
  logic signed [31:0] lnv, denc;
  logic [21:0]        rem_sh;
  logic               ge;
  logic [31:0]        ynew, diff;
  logic [CW-1:0]      cnt_inc;
  logic               conv;

  always_comb begin
    idx_prod = 64'(v_r[54:23]) * 64'(LOG_TABLE_DEPTH);
    lnv = (signed'({26'b0, p_r}) - 32'sd32) * LN2_Q16 + signed'(32'(t_r));
    denc = lnv + ONE_Q16;
    rem_sh = {rem_r, dvd_r[bit_r]};
    ge = rem_sh >= {1'b0, den_r};
    ynew = over_r ? '1 : q_r;
    diff = (ynew >= y_r) ? ynew - y_r : y_r - ynew;
    cnt_inc = cnt_r + CW'(1);
    conv = (39'(diff) * 39'd100) <= 39'(YPLUS_START);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            if (q_data.invalid) begin
              out_valid_r <= 1'b1;
              out_y_r <= '0;
              out_cnt_r <= '0;
              out_st_r <= ST_INVALID;
            end else begin
              kre_r <= q_data.kre;
              y_r <= YPLUS_START;
              cnt_r <= '0;
              state_r <= B_MUL;
            end
          end
        end
        B_MUL: begin
          v_r <= 56'(e_val) * 56'(y_r);
          p_r <= 6'd55;
          state_r <= B_NORM;
        end
        B_NORM: begin
          if (v_r == '0) begin
            out_valid_r <= 1'b1;
            out_y_r <= '0;
            out_cnt_r <= 4'(cnt_r);
            out_st_r <= ST_DEGEN;
            state_r <= B_IDLE;
          end else if (v_r[55:48] == '0) begin
            v_r <= v_r << 8;
            p_r <= p_r - 6'd8;
          end else if (!v_r[55]) begin
            v_r <= v_r << 1;
            p_r <= p_r - 6'd1;
          end else begin
            state_r <= B_IDX;
          end
        end
        B_IDX: begin
          idx_r <= idx_prod[32 +: IW];
          state_r <= B_ROM;
        end
        B_ROM: begin
          t_r <= ln_rom[idx_r];
          state_r <= B_DEN;
        end
        B_DEN: begin
          if (denc <= 32'sd0) begin
            out_valid_r <= 1'b1;
            out_y_r <= '0;
            out_cnt_r <= 4'(cnt_r);
            out_st_r <= ST_DEGEN;
            state_r <= B_IDLE;
          end else begin
            den_r <= denc[20:0];
            dvd_r <= {49'(kre_r) + 49'(y_r), 16'b0};
            rem_r <= '0;
            bit_r <= 7'd64;
            q_r <= '0;
            over_r <= 1'b0;
            state_r <= B_DIV;
          end
        end
        B_DIV: begin
          rem_r <= ge ? 21'(rem_sh - {1'b0, den_r}) : rem_sh[20:0];
          if (ge && (bit_r >= 7'd32)) over_r <= 1'b1;
          if (bit_r < 7'd32) q_r <= {q_r[30:0], ge};
          if (bit_r == '0) state_r <= B_UPD;
          else bit_r <= bit_r - 7'd1;
        end
        B_UPD: begin
          y_r <= ynew;
          cnt_r <= cnt_inc;
          if (conv || (cnt_inc == CW'(MAX_UPDATES))) begin
            out_valid_r <= 1'b1;
            out_y_r <= ynew;
            out_cnt_r <= 4'(cnt_inc);
            out_st_r <= conv ? ST_CONVERGED : ST_MAXED;
            state_r <= B_IDLE;
          end else begin
            state_r <= B_MUL;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign q_pop = (state_r == B_IDLE) && !q_empty;
  assign out_valid = out_valid_r;
  assign out_yplus_value = out_y_r;
  assign out_update_count = out_cnt_r;
  assign out_solve_status = out_st_r;

  `LLYS_ASSERT(a_maxed_count, clk, rst_n, (out_valid_r && out_st_r == ST_MAXED) |-> (out_cnt_r == 4'(MAX_UPDATES)), "stop short of the update limit")
  `LLYS_ASSERT(a_invalid_zero, clk, rst_n, (out_valid_r && out_st_r == ST_INVALID) |-> (out_y_r == '0 && out_cnt_r == '0), "invalid result not cleared")
  `LLYS_ASSERT(a_conv_count, clk, rst_n, (out_valid_r && out_st_r == ST_CONVERGED) |-> (out_cnt_r != '0), "convergence without update")

endmodule
